// ===== src/vaq_pkg.sv =====
// Shared types, codes and constants of the voice allocation queue.
`default_nettype none
package vaq_pkg;

   // Field widths of the request and response words
   localparam int VoiceW     = 3;
   localparam int InstW      = 8;
   localparam int ModeW      = 8;
   localparam int CountW     = 8;
   localparam int FuncW      = 2;
   localparam int ReqDataW   = 32;
   localparam int RspDataW   = 8;

   // Default number of voices and its allowed range is 2 .. 8
   localparam int NumVoicesDefault = 6;

   // Modulo unit: four restoring steps per cycle over the 8-bit dividend
   localparam int DivBitsPerCycle = 4;

   // Owner code written into every entry at reset
   localparam logic [InstW-1:0] InstNone = 8'hff;

   // Assignment modes; every code from DedicatedBase up selects one voice
   localparam logic [ModeW-1:0] ModeAll       = 8'd0;
   localparam logic [ModeW-1:0] ModeLeft      = 8'd1;
   localparam logic [ModeW-1:0] ModeRight     = 8'd2;
   localparam logic [ModeW-1:0] DedicatedBase = 8'd3;

   typedef enum logic [FuncW-1:0] {
      FUNC_GET       = 2'd0,
      FUNC_GET_LAST  = 2'd1,
      FUNC_RELEASE   = 2'd2,
      FUNC_CLR_EXCL  = 2'd3
   } vaq_func_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_MOVE_GET   = 3'd1,
      ACT_MOVE_REUSE = 3'd2,
      ACT_RELEASE    = 3'd3,
      ACT_CLR_EXCL   = 3'd4
   } vaq_act_type;

   typedef struct packed {
      logic [VoiceW-1:0] voice;
      logic              assigned;
      logic              exclusive;
      logic [InstW-1:0]  instrument;
   } vaq_entry_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic search;
      logic commit;
   } vaq_cmd_type;

   typedef struct packed {
      logic div_last;
   } vaq_status_type;

endpackage
`default_nettype wire

// ===== src/voice_allocation_queue_unit.sv =====
// Top level of the voice allocation queue: sequencer plus datapath.
//
// Use: a synthesizer sends one request word per note event on the req_
// channel; req_tuser carries the function (get, get last, release, clear
// exclusive flags), req_tdata the instrument, assignment mode, voice count
// and voice number. Each request produces exactly one response word on the
// rsp_ channel: the voice number in rsp_tdata, and rsp_tuser high when no
// suitable voice existed (the voice number is then zero).
// Timing: an accepted request passes through the modulo unit (four quotient
// bits per cycle over the 8-bit mode offset), a search over the queue and a
// queue update; rsp_tvalid rises as that update is registered. req_tready
// rises again after that update, so the block takes a new request only once
// the previous one has been committed.
// Stall: the response sits in an output register; while the receiver holds
// rsp_tready low a further request is still accepted and processed, and
// its update waits until the pending word is taken; req_tready stays low
// meanwhile, so the input stalls.
// Reset: synchronous, active high; the queue returns to voice i at place i,
// all flags clear and no owner, and no response is pending.
`default_nettype none
module voice_allocation_queue_unit #(
   parameter int VOICE_SLOTS = vaq_pkg::NumVoicesDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [7:0] instrument, [15:8] assign_mode, [23:16] voice_count,
   // [26:24] voice_in, [31:27] zero
   input  wire logic [vaq_pkg::ReqDataW-1:0]  req_tdata,
   // [1:0] func
   input  wire logic [vaq_pkg::FuncW-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [2:0] voice_out, [7:3] zero
   output logic [vaq_pkg::RspDataW-1:0]       rsp_tdata,
   // [0] not_found
   output logic                               rsp_tuser
);

   vaq_pkg::vaq_cmd_type    cmd;
   vaq_pkg::vaq_status_type status;

   // sequencing and handshakes
   vaq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // queue storage, modulo, search and update
   vaq_dpath #(
      .VOICE_SLOTS (VOICE_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== src/vaq_ctrl.sv =====
// Sequencer of the voice allocation queue: handshakes and step commands.
`default_nettype none
module vaq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output vaq_pkg::vaq_cmd_type         cmd,
   input  wire vaq_pkg::vaq_status_type status
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DIV    = 4'b0010,
      S_SEARCH = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/vaq_dpath.sv =====
// Datapath of the voice allocation queue: queue, modulo unit, search, update.
`default_nettype none
module vaq_dpath #(
   parameter int VOICE_SLOTS = vaq_pkg::NumVoicesDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vaq_pkg::vaq_cmd_type          cmd,
   output vaq_pkg::vaq_status_type            status,
   input  wire logic [vaq_pkg::ReqDataW-1:0]  req_tdata,
   input  wire logic [vaq_pkg::FuncW-1:0]     req_tuser,
   output logic [vaq_pkg::RspDataW-1:0]       rsp_tdata,
   output logic                               rsp_tuser
);

   localparam int PosW  = $clog2(VOICE_SLOTS);
   localparam int Half  = VOICE_SLOTS / 2;
   localparam int NumW  = $clog2(VOICE_SLOTS + 1);
   localparam int VW    = vaq_pkg::VoiceW;
   localparam int IW    = vaq_pkg::InstW;
   localparam int MW    = vaq_pkg::ModeW;
   localparam int CW    = vaq_pkg::CountW;
   localparam int DivCycles = MW / vaq_pkg::DivBitsPerCycle;
   localparam int StepW = (DivCycles > 1) ? $clog2(DivCycles) : 1;

   // Latched request
   vaq_pkg::vaq_func_type func_ff;
   logic [IW-1:0]         inst_ff;
   logic [MW-1:0]         mode_ff;
   logic [CW-1:0]         count_ff;
   logic [VW-1:0]         vin_ff;

   // Modulo unit
   logic [MW-1:0]         dvd_ff, dvd_in;
   logic [VW-1:0]         rem_ff, rem_in;
   logic [StepW-1:0]      step_ff;

   // Search result
   vaq_pkg::vaq_act_type  act_ff, act_in;
   logic [PosW-1:0]       pos_ff, pos_in;
   logic                  excl_new_ff;

   // Queue, oldest first
   vaq_pkg::vaq_entry_type q_ff [VOICE_SLOTS];
   vaq_pkg::vaq_entry_type q_in [VOICE_SLOTS];

   // Response register
   logic [VW-1:0]         voice_out_ff, voice_out_in;
   logic                  not_found_ff, not_found_in;

   logic [NumW-1:0]        num_w;
   logic [VW:0]            div_w;
   logic                   dedicated;
   logic [VOICE_SLOTS-1:0] qual, vin_hit;
   logic                   get_found, vin_found, reuse;
   logic [PosW-1:0]        get_pos, vin_pos;

   assign status.div_last = (step_ff == StepW'(DivCycles - 1));
   assign rsp_tdata       = {(vaq_pkg::RspDataW - VW)'(0), voice_out_ff};
   assign rsp_tuser       = not_found_ff;

   // voices usable by the instrument, and the modulo divisor with zero read as one
   always_comb begin
      num_w = (count_ff > CW'(VOICE_SLOTS)) ? NumW'(VOICE_SLOTS) : count_ff[NumW-1:0];
      div_w = (num_w == '0) ? (VW+1)'(1) : (VW+1)'(num_w);
   end

   assign dedicated = (mode_ff >= vaq_pkg::DedicatedBase);

   // restoring modulo, several bits a cycle
   always_comb begin
      logic [VW:0]   r;
      logic [MW-1:0] d;
      r = {1'b0, rem_ff};
      d = dvd_ff;
      for (int k = 0; k < vaq_pkg::DivBitsPerCycle; k++) begin
         r = {r[VW-1:0], d[MW-1]};
         d = {d[MW-2:0], 1'b0};
         if (r >= div_w) begin
            r = r - div_w;
         end
      end
      rem_in = r[VW-1:0];
      dvd_in = d;
   end

   // qualify every entry
   always_comb begin
      logic [VW-1:0] v;
      logic          allowed;
      for (int i = 0; i < VOICE_SLOTS; i++) begin
         v = q_ff[i].voice;
         priority if (mode_ff == vaq_pkg::ModeAll) begin
            allowed = 1'b1;
         end else if (mode_ff == vaq_pkg::ModeLeft) begin
            allowed = (v < VW'(Half));
         end else if (mode_ff == vaq_pkg::ModeRight) begin
            if (num_w <= NumW'(Half)) begin
               allowed = (v < VW'(Half));
            end else begin
               allowed = (v >= VW'(Half)) && ({1'b0, v} < (VW+1)'(2 * Half));
            end
         end else begin
            allowed = (v == rem_ff);
         end
         qual[i]    = allowed &&
                      (!q_ff[i].exclusive || (q_ff[i].instrument == inst_ff) || dedicated);
         vin_hit[i] = (v == vin_ff);
      end
   end

   // first matching entry from the head
   always_comb begin
      get_found = 1'b0;
      get_pos   = '0;
      vin_found = 1'b0;
      vin_pos   = '0;
      for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
         if (qual[i]) begin
            get_found = 1'b1;
            get_pos   = PosW'(i);
         end
         if (vin_hit[i]) begin
            vin_found = 1'b1;
            vin_pos   = PosW'(i);
         end
      end
   end

   assign reuse = vin_found && (q_ff[vin_pos].instrument == inst_ff) &&
                  ({(CW - VW)'(0), vin_ff} < count_ff);

   always_comb begin
      act_in = vaq_pkg::ACT_NONE;
      pos_in = get_pos;
      unique case (func_ff)
         vaq_pkg::FUNC_GET: begin
            act_in = get_found ? vaq_pkg::ACT_MOVE_GET : vaq_pkg::ACT_NONE;
         end
         vaq_pkg::FUNC_GET_LAST: begin
            if (reuse) begin
               act_in = vaq_pkg::ACT_MOVE_REUSE;
               pos_in = vin_pos;
            end else begin
               act_in = get_found ? vaq_pkg::ACT_MOVE_GET : vaq_pkg::ACT_NONE;
            end
         end
         vaq_pkg::FUNC_RELEASE: begin
            act_in = vin_found ? vaq_pkg::ACT_RELEASE : vaq_pkg::ACT_NONE;
            pos_in = vin_pos;
         end
         vaq_pkg::FUNC_CLR_EXCL: begin
            act_in = vaq_pkg::ACT_CLR_EXCL;
         end
         default: begin
            act_in = vaq_pkg::ACT_NONE;
         end
      endcase
   end

   // queue update and result
   always_comb begin
      vaq_pkg::vaq_entry_type moved;
      for (int i = 0; i < VOICE_SLOTS; i++) begin
         q_in[i] = q_ff[i];
      end
      moved        = q_ff[pos_ff];
      voice_out_in = '0;
      not_found_in = 1'b0;
      unique case (act_ff)
         vaq_pkg::ACT_MOVE_GET, vaq_pkg::ACT_MOVE_REUSE: begin
            moved.assigned = 1'b1;
            if (act_ff == vaq_pkg::ACT_MOVE_GET) begin
               moved.exclusive  = excl_new_ff;
               moved.instrument = inst_ff;
            end
            for (int i = 0; i < VOICE_SLOTS - 1; i++) begin
               if (PosW'(i) >= pos_ff) begin
                  q_in[i] = q_ff[i + 1];
               end
            end
            q_in[VOICE_SLOTS - 1] = moved;
            voice_out_in          = moved.voice;
         end
         vaq_pkg::ACT_RELEASE: begin
            q_in[pos_ff].assigned = 1'b0;
            voice_out_in          = q_ff[pos_ff].voice;
         end
         vaq_pkg::ACT_CLR_EXCL: begin
            for (int i = 0; i < VOICE_SLOTS; i++) begin
               q_in[i].exclusive = 1'b0;
            end
         end
         vaq_pkg::ACT_NONE: begin
            not_found_in = 1'b1;
         end
         default: begin
            not_found_in = 1'b1;
         end
      endcase
   end

   // request latch and modulo unit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         inst_ff  <= req_tdata[IW-1:0];
         mode_ff  <= req_tdata[IW +: MW];
         count_ff <= req_tdata[IW+MW +: CW];
         vin_ff   <= req_tdata[IW+MW+CW +: VW];
         func_ff  <= vaq_pkg::vaq_func_type'(req_tuser);
         dvd_ff   <= req_tdata[IW +: MW] - vaq_pkg::DedicatedBase;
         rem_ff   <= '0;
         step_ff  <= '0;
      end else if (cmd.div_step) begin
         dvd_ff   <= dvd_in;
         rem_ff   <= rem_in;
         step_ff  <= step_ff + StepW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         act_ff      <= act_in;
         pos_ff      <= pos_in;
         excl_new_ff <= dedicated;
      end
      if (cmd.commit) begin
         voice_out_ff <= voice_out_in;
         not_found_ff <= not_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICE_SLOTS; i++) begin
            q_ff[i].voice      <= VW'(i);
            q_ff[i].assigned   <= 1'b0;
            q_ff[i].exclusive  <= 1'b0;
            q_ff[i].instrument <= vaq_pkg::InstNone;
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < VOICE_SLOTS; i++) begin
            q_ff[i] <= q_in[i];
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/vaq_checker.sv =====
// Port-level checks of the voice allocation queue and their binding.
`default_nettype none
module vaq_checker #(
   parameter int VOICE_SLOTS = vaq_pkg::NumVoicesDefault
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [vaq_pkg::RspDataW-1:0]  rsp_tdata,
   input wire logic                          rsp_tuser
);

   localparam int VW = vaq_pkg::VoiceW;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // an error answer carries voice zero
   a_err_voice: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[VW-1:0] == '0)
      else $error("error response with nonzero voice");

   // every voice returned exists
   a_voice_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, rsp_tdata} < (vaq_pkg::RspDataW + 1)'(VOICE_SLOTS))
      else $error("voice out of range");

   // one request at a time: busy right after an accepted word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // nothing pending after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

endmodule

bind voice_allocation_queue_unit vaq_checker #(
   .VOICE_SLOTS (VOICE_SLOTS)
) u_vaq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== bench/voice_allocation_queue_unit_test.sv =====
// Self-checking bench for the voice allocation queue: a tracker predicts every response word.

class voice_pool_tracker;
   localparam int Slots = vaq_pkg::NumVoicesDefault;

   typedef struct {
      logic [vaq_pkg::VoiceW-1:0] voice;
      logic                       miss;
   } grant_word;

   vaq_pkg::vaq_entry_type     slots[Slots];
   grant_word                  owed[$];
   logic [vaq_pkg::VoiceW-1:0] last_grant;
   int                         fail_count;
   int                         taken;
   int                         checked;
   int                         misses;
   int                         reuses;

   function new();
      for (int i = 0; i < Slots; i++) begin
         slots[i].voice      = i[vaq_pkg::VoiceW-1:0];
         slots[i].assigned   = 1'b0;
         slots[i].exclusive  = 1'b0;
         slots[i].instrument = vaq_pkg::InstNone;
      end
      last_grant = '0;
   endfunction

   // Rotate the entry at pos to the tail; everything behind it moves up one place.
   function void shift_to_tail(int pos);
      vaq_pkg::vaq_entry_type keep;
      keep = slots[pos];
      for (int i = pos; i < Slots - 1; i++)
         slots[i] = slots[i + 1];
      slots[Slots - 1] = keep;
   endfunction

   function int locate(logic [vaq_pkg::VoiceW-1:0] v);
      for (int i = 0; i < Slots; i++)
         if (slots[i].voice == v)
            return i;
      return -1;
   endfunction

   // Search the queue oldest first for an allowed, claimable voice.
   function bit pick_voice(logic [7:0] inst, logic [7:0] mode, logic [7:0] count,
                           output logic [vaq_pkg::VoiceW-1:0] v);
      int unsigned n;
      int unsigned half;
      int unsigned allowed;
      bit          dedicated;
      n         = (count > Slots) ? Slots : count;
      half      = (1 << (Slots / 2)) - 1;
      dedicated = (mode >= vaq_pkg::DedicatedBase);
      if (mode == vaq_pkg::ModeAll)
         allowed = (1 << Slots) - 1;
      else if (mode == vaq_pkg::ModeLeft)
         allowed = half;
      else if (mode == vaq_pkg::ModeRight)
         allowed = (n <= Slots / 2) ? half : (half << (Slots / 2));
      else
         allowed = 1 << ((int'(mode) - int'(vaq_pkg::DedicatedBase)) % ((n == 0) ? 1 : n));
      for (int i = 0; i < Slots; i++) begin
         if (allowed[slots[i].voice] &&
             (!slots[i].exclusive || slots[i].instrument == inst || dedicated)) begin
            slots[i].assigned   = 1'b1;
            slots[i].exclusive  = dedicated;
            slots[i].instrument = inst;
            shift_to_tail(i);
            v = slots[Slots - 1].voice;
            return 1'b1;
         end
      end
      v = '0;
      return 1'b0;
   endfunction

   // Apply one accepted request word and queue the response it must produce.
   function void take_request(vaq_pkg::vaq_func_type f, logic [7:0] inst, logic [7:0] mode,
                              logic [7:0] count, logic [vaq_pkg::VoiceW-1:0] vin);
      grant_word g;
      int        pos;
      bit        ok;
      g.voice = '0;
      ok      = 1'b1;
      taken++;
      case (f)
         vaq_pkg::FUNC_GET: begin
            ok = pick_voice(inst, mode, count, g.voice);
         end
         vaq_pkg::FUNC_GET_LAST: begin
            pos = locate(vin);
            if (pos >= 0 && slots[pos].instrument == inst && slots[pos].voice < count) begin
               slots[pos].assigned = 1'b1;
               shift_to_tail(pos);
               g.voice = slots[Slots - 1].voice;
               reuses++;
            end else begin
               ok = pick_voice(inst, mode, count, g.voice);
            end
         end
         vaq_pkg::FUNC_RELEASE: begin
            pos = locate(vin);
            if (pos >= 0) begin
               slots[pos].assigned = 1'b0;
               g.voice = slots[pos].voice;
            end else begin
               ok = 1'b0;
            end
         end
         default: begin
            for (int i = 0; i < Slots; i++)
               slots[i].exclusive = 1'b0;
         end
      endcase
      g.miss = !ok;
      if (ok && f != vaq_pkg::FUNC_CLR_EXCL)
         last_grant = g.voice;
      else
         misses += !ok;
      owed.push_back(g);
   endfunction

   // Compare one response word against the oldest prediction.
   function void match_response(logic [vaq_pkg::VoiceW-1:0] v, logic miss);
      grant_word g;
      if (owed.size() == 0) begin
         $display("%0t: response with nothing outstanding: voice %0d not_found %0b",
                  $time, v, miss);
         fail_count++;
         return;
      end
      g = owed.pop_front();
      checked++;
      if (g.voice !== v) begin
         $display("%0t: voice_out mismatch: expected %0d, actual %0d", $time, g.voice, v);
         fail_count++;
      end
      if (g.miss !== miss) begin
         $display("%0t: not_found mismatch: expected %0b, actual %0b", $time, g.miss, miss);
         fail_count++;
      end
   endfunction
endclass

module voice_allocation_queue_unit_test;
   import vaq_pkg::*;

   localparam int Slots       = NumVoicesDefault;
   localparam int RandomItems = 1830;
   localparam int HoldCycles  = 48;
   localparam int QuietItems  = 200;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic [FuncW-1:0]    req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;

   voice_pool_tracker   tracker;
   bit                  hold_off_now = 1'b0;  // ask the receiver for one long stall
   bit                  quiet_phase  = 1'b0;  // no idling from either side

   voice_allocation_queue_unit #(.VOICE_SLOTS(Slots)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Present one request word at the falling edge and hold it until the block takes it.
   // The caller's next word follows on the next falling edge, so tvalid stays high.
   task automatic send_request(vaq_func_type f, logic [7:0] inst, logic [7:0] mode,
                               logic [7:0] count, logic [VoiceW-1:0] vin);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {5'b0, vin, count, mode, inst};
      do
         @(posedge clock);
      while (!req_tready);
      tracker.take_request(f, inst, mode, count, vin);
   endtask

   // Drop tvalid for a burst of cycles.
   task automatic sender_gap(int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop tvalid and hold further words until every predicted response has been taken.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.owed.size() != 0)
         @(posedge clock);
   endtask

   // Build one random word, biased toward a small set of instruments and recent voices
   // so that reuse, exclusive conflicts and fallbacks happen often.
   task automatic random_request(bit may_idle);
      vaq_func_type  f;
      logic [7:0]    inst;
      logic [7:0]    mode;
      logic [7:0]    count;
      logic [2:0]    vin;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         f = FUNC_GET;
      else if (pick < 65)
         f = FUNC_GET_LAST;
      else if (pick < 90)
         f = FUNC_RELEASE;
      else
         f = FUNC_CLR_EXCL;

      pick = $urandom_range(0, 9);
      if (pick == 0)
         inst = 8'($urandom_range(0, 255));
      else if (pick == 1)
         inst = InstNone;
      else
         inst = 8'($urandom_range(0, 2));

      pick = $urandom_range(0, 9);
      if (pick < 6)
         mode = 8'($urandom_range(0, 2));
      else if (pick < 9)
         mode = DedicatedBase + 8'($urandom_range(0, 7));
      else
         mode = 8'($urandom_range(0, 255));

      pick = $urandom_range(0, 9);
      if (pick < 5)
         count = 8'(Slots);
      else if (pick < 9)
         count = 8'($urandom_range(0, 8));
      else
         count = 8'($urandom_range(0, 255));

      vin = $urandom_range(0, 1) ? tracker.last_grant : 3'($urandom_range(0, 7));

      send_request(f, inst, mode, count, vin);
      if (may_idle && $urandom_range(0, 3) == 0)
         sender_gap($urandom_range(1, 4));
   endtask

   // Receiver: stall in short random bursts, once for a long stretch, never when quiet.
   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_now) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
            hold_off_now = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check every response word taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_response(rsp_tdata[VoiceW-1:0], rsp_tuser);
   end

   initial begin : watchdog
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      tracker    = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_GET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every mode, both halves, the n=0 modulo, extreme fields.
      send_request(FUNC_GET, 8'd0, ModeAll, 8'd6, 3'd0);
      send_request(FUNC_GET, 8'd1, ModeLeft, 8'd6, 3'd0);
      send_request(FUNC_GET, 8'd2, ModeRight, 8'd6, 3'd0);
      // right half folds onto the left when few voices are given
      send_request(FUNC_GET, 8'd2, ModeRight, 8'd3, 3'd0);
      // a voice count of zero counts as one in the modulo
      send_request(FUNC_GET, 8'd3, DedicatedBase, 8'd0, 3'd0);
      send_request(FUNC_GET, 8'd3, 8'hff, 8'hff, 3'd7);
      send_request(FUNC_GET, 8'd3, DedicatedBase + 8'd1, 8'd6, 3'd0);
      send_request(FUNC_GET, 8'd3, DedicatedBase + 8'd2, 8'd6, 3'd0);
      // left half now held exclusively by another instrument: nothing found
      send_request(FUNC_GET, 8'd4, ModeLeft, 8'd6, 3'd0);
      // reuse by the owner, then fallbacks: wrong owner, voice out of range, count too low
      send_request(FUNC_GET_LAST, 8'd3, ModeAll, 8'd6, 3'd1);
      send_request(FUNC_GET_LAST, 8'd4, ModeAll, 8'd6, 3'd1);
      send_request(FUNC_GET_LAST, 8'd3, ModeAll, 8'd6, 3'd7);
      send_request(FUNC_GET_LAST, 8'd3, ModeAll, 8'd2, 3'd2);
      send_request(FUNC_RELEASE, 8'd3, ModeAll, 8'd6, 3'd0);
      // releases of voices that do not exist
      send_request(FUNC_RELEASE, 8'd3, ModeAll, 8'd6, 3'd7);
      send_request(FUNC_RELEASE, 8'd3, ModeAll, 8'd6, 3'(Slots));
      send_request(FUNC_CLR_EXCL, 8'd0, ModeAll, 8'd0, 3'd0);
      send_request(FUNC_GET, 8'd4, ModeLeft, 8'd6, 3'd0);
      send_request(FUNC_GET, 8'hff, ModeAll, 8'hff, 3'd0);
      send_request(FUNC_GET_LAST, 8'd0, ModeRight, 8'd5, 3'd5);
      send_request(FUNC_GET, 8'd7, 8'hff, 8'd7, 3'd3);

      for (int k = 0; k < RandomItems; k++) begin
         if (k == 600)
            hold_off_now = 1'b1;  // receiver stalls while words keep coming
         if (k == 1200)
            wait_drained();
         if (k == RandomItems - QuietItems)
            quiet_phase = 1'b1;
         // back to back while the long stall builds up back-pressure
         random_request(!quiet_phase && !(k >= 600 && k < 615));
      end
      sender_gap(1);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Ran %0d requests; %0d responses checked, %0d not-found answers, %0d voice reuses.",
               tracker.taken, tracker.checked, tracker.misses, tracker.reuses);
      $display("Covered all modes, exclusive conflicts, long back-pressure and a full drain.");
      if (tracker.fail_count == 0 && tracker.owed.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/vaq_pkg.sv
src/vaq_ctrl.sv
src/vaq_dpath.sv
src/voice_allocation_queue_unit.sv
src/vaq_checker.sv
bench/voice_allocation_queue_unit_test.sv
